// File: rtl/edf_pkg.sv
// Shared types and constants for the EDF tick scheduler.
// Used by edf_ctrl, edf_datapath and edf_tick_scheduler; no dependencies.
package edf_pkg;

  // Task slot storage
  localparam int MAX_TASKS = 8;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int CFG_W     = 4;
  localparam int SLOT_W    = 3;
  localparam int PID_W     = 16;
  localparam int TICK_W    = 16;
  localparam int TIME_W    = 32;

  // Input item opcodes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot;
    logic [PID_W-1:0]  task_pid;
    logic [TICK_W-1:0] burst;
    logic [TICK_W-1:0] rel_deadline;
    logic [TICK_W-1:0] period;
  } in_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] tick_time;
    logic              cpu_idle;
    logic [SLOT_W-1:0] run_slot;
    logic [PID_W-1:0]  run_pid;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // write one slot and restart the schedule
    logic start;      // begin a tick: reset scan index and winner
    logic scan_step;  // release and compare one slot
    logic finish;     // charge the winner, emit result, advance time
  } edf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic n_zero;     // no slots in use
    logic scan_last;  // current scan slot is the last one in use
    logic out_full;   // result register holds a stalled transfer
  } edf_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } edf_state_t;

endpackage

// File: rtl/edf_ctrl.sv
// Sequencer for the EDF tick scheduler: accepts items and steps the slot scan.
// Depends on edf_pkg for the command, status and state types.
module edf_ctrl
  import edf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_func,
  output logic     in_stall,
  input  edf_sts_t sts,
  output edf_cmd_t cmd
);

  edf_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_func == FUNC_TICK) begin
            cmd.start = 1'b1;
            state_nxt = sts.n_zero ? ST_FINISH : ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the result register frees up
        if (!sts.out_full) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Never overwrite a result that is still waiting for transfer
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !sts.out_full)
    else $error("finish issued while result register is full");

  // A tick with slots in use always goes through the scan
  a_tick_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.start && !sts.n_zero) |=> (state_r == ST_SCAN))
    else $error("tick did not enter scan");

  // Commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one command active");

endmodule

// File: rtl/edf_datapath.sv
// Task tables, per-slot release state, one-slot-per-cycle EDF compare and result register.
// Depends on edf_pkg for item, command and status types.
module edf_datapath
  import edf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  in_item_t         in_data,
  input  edf_cmd_t         cmd,
  output edf_sts_t         sts,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  localparam int EXT_W = CFG_W + CNT_W;

  // Configuration and time
  logic [CFG_W-1:0]  num_tasks_r;
  logic [TIME_W-1:0] now_r;

  // Slot tables
  logic [PID_W-1:0]  pid_r   [MAX_TASKS];
  logic [TICK_W-1:0] burst_r [MAX_TASKS];
  logic [TICK_W-1:0] dl_r    [MAX_TASKS];
  logic [TICK_W-1:0] per_r   [MAX_TASKS];
  logic [TICK_W-1:0] wl_r    [MAX_TASKS];
  logic [TIME_W-1:0] due_r   [MAX_TASKS];
  logic [TICK_W-1:0] cd_r    [MAX_TASKS];

  // Scan state
  logic [IDX_W-1:0]  idx_r;
  logic [CNT_W-1:0]  n_r;
  logic              found_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [TIME_W-1:0] best_due_r;
  logic [TICK_W-1:0] best_wl_r;
  logic [PID_W-1:0]  best_pid_r;

  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [EXT_W-1:0]  cfg_ext;
  logic [CNT_W-1:0]  active_cnt;
  logic              slot_ok;
  logic [IDX_W-1:0]  load_idx;
  logic              release_now;
  logic [TICK_W-1:0] per_m1;
  logic [TICK_W-1:0] wl_nxt;
  logic [TIME_W-1:0] due_nxt;
  logic [TICK_W-1:0] cd_nxt;
  logic              take;

  // Clamp slot count to the table size
  assign cfg_ext    = EXT_W'(num_tasks_r);
  assign active_cnt = (cfg_ext > EXT_W'(MAX_TASKS)) ? CNT_W'(MAX_TASKS) : CNT_W'(cfg_ext);
  assign slot_ok    = (EXT_W'(in_data.slot) < EXT_W'(MAX_TASKS));
  assign load_idx   = IDX_W'(in_data.slot);

  // Release and compare the slot under the scan index
  assign release_now = (cd_r[idx_r] == '0);
  assign per_m1      = (per_r[idx_r] == '0) ? '0 : per_r[idx_r] - TICK_W'(1);
  assign wl_nxt      = release_now ? burst_r[idx_r] : wl_r[idx_r];
  assign due_nxt     = release_now ? now_r + TIME_W'(dl_r[idx_r]) : due_r[idx_r];
  assign cd_nxt      = release_now ? per_m1 : cd_r[idx_r] - TICK_W'(1);
  assign take        = (wl_nxt != '0) && (!found_r || (due_nxt < best_due_r));

  assign sts.n_zero    = (active_cnt == '0);
  assign sts.scan_last = ((CNT_W'(idx_r) + CNT_W'(1)) == n_r);
  assign sts.out_full  = out_valid_r && out_stall;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_tasks_r <= '0;
    end else if (cfg_wr_en) begin
      num_tasks_r <= cfg_wr_data;
    end
  end

  // Tables, time and per-slot release state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        pid_r[i]   <= '0;
        burst_r[i] <= '0;
        dl_r[i]    <= '0;
        per_r[i]   <= TICK_W'(1);
        wl_r[i]    <= '0;
        due_r[i]   <= '0;
        cd_r[i]    <= '0;
      end
    end else if (cmd.load) begin
      if (slot_ok) begin
        pid_r[load_idx]   <= in_data.task_pid;
        burst_r[load_idx] <= in_data.burst;
        dl_r[load_idx]    <= in_data.rel_deadline;
        per_r[load_idx]   <= in_data.period;
        now_r             <= '0;
        for (int i = 0; i < MAX_TASKS; i++) begin
          wl_r[i] <= '0;
          cd_r[i] <= '0;
        end
      end
    end else if (cmd.scan_step) begin
      wl_r[idx_r]  <= wl_nxt;
      due_r[idx_r] <= due_nxt;
      cd_r[idx_r]  <= cd_nxt;
    end else if (cmd.finish) begin
      if (found_r) begin
        wl_r[best_idx_r] <= best_wl_r - TICK_W'(1);
      end
      now_r <= now_r + TIME_W'(1);
    end
  end

  // Scan index and running winner
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      n_r     <= '0;
      found_r <= 1'b0;
    end else if (cmd.start) begin
      idx_r   <= '0;
      n_r     <= active_cnt;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + IDX_W'(1);
      if (take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && take) begin
      best_idx_r <= idx_r;
      best_due_r <= due_nxt;
      best_wl_r  <= wl_nxt;
      best_pid_r <= pid_r[idx_r];
    end
  end

  // Result register: load on finish, drop after transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.tick_time <= now_r;
      out_data_r.cpu_idle  <= !found_r;
      out_data_r.run_slot  <= found_r ? SLOT_W'(best_idx_r) : '0;
      out_data_r.run_pid   <= found_r ? best_pid_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Winner always lies inside the slots scanned this tick
  a_winner_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && found_r) |-> (CNT_W'(best_idx_r) < n_r))
    else $error("winner outside active slots");

  // A new result only appears right after a finish
  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.finish))
    else $error("result valid without finish");

  // A charged winner had pending work
  a_winner_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && found_r) |-> (best_wl_r != '0))
    else $error("winner with no pending work");

endmodule

// File: rtl/edf_tick_scheduler.sv
// Periodic earliest-deadline-first tick scheduler, top level.
// Load item: writes one slot and gives no result. Tick item: the controller scans the N active
// slots (N clamped to 8), then finishes into the result register; one slot is released and compared
// per cycle by the single deadline comparator, and the next item is taken only after the finish.
// The result register lets the next item enter while a result waits for transfer.
// Synchronous active-low reset clears time, tables (period to 1) and slot count.
module edf_tick_scheduler
  import edf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  edf_cmd_t cmd;
  edf_sts_t sts;

  // Sequencer
  edf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_data.func),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables, scan and result register
  edf_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
